@@ rtl/bia_pkg.sv @@
// Shared types and codes for the bitmap ID allocator.
// No dependencies; imported by the allocator, the checker and the testbench.
package bia_pkg;

  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned BIT_IDX_W = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } st_t;

  typedef enum logic {
    FUNC_ALLOC   = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOT_HELD = 2'd2
  } status_t;

  typedef logic [WORD_BITS-1:0] word_t;

endpackage

@@ rtl/bitmap_id_allocator.sv @@
// Bitmap ID allocator: lowest-free allocate and checked release over a held-ID bitmap.
// Flow: a request is accepted in IDLE, its bitmap word is read in READ and evaluated in EVAL;
// an allocate whose word is full moves on to the next word and returns to READ.
// One word at a time: each word costs a registered RAM read and one priority scan.
// Throughput: one request in flight; the next is taken once the result is registered.
// Reset (rst_n, synchronous): per-word valid flags clear, so the bitmap reads as empty
// and the held count is zero at once; no clearing pass.
module bitmap_id_allocator #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] id_in
  input  logic [0:0]  in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] id_out, [16:8] held_count, [17] any_held
  output logic [1:0]  out_tuser   // [1:0] status
);

  import bia_pkg::*;

  localparam int unsigned WORD_COUNT = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned TW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(WORD_COUNT - 1);
  localparam logic [TW-1:0] CAP_T = TW'(CAPACITY);
  localparam word_t ALL_ONES = '1;

  st_t             state_r, state_nxt;
  func_t           func_r, func_nxt;
  logic [7:0]      id_r, id_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [TW-1:0]   total_r, total_nxt;
  logic            vld_r [WORD_COUNT];
  logic            vld_q_r;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_id_r, out_id_nxt;
  status_t         out_stat_r, out_stat_nxt;
  logic [TW-1:0]   out_total_r, out_total_nxt;

  word_t           rdata;
  word_t           word_w;
  word_t           wdata;
  logic            we;
  logic            emit;
  logic            can_emit;
  logic [BIT_IDX_W-1:0] low_b;
  logic [AW+BIT_IDX_W-1:0] cand;
  logic [AW-1:0]   rel_word;
  logic            id_in_range;
  logic            held_bit;
  logic            accept;

  function automatic logic [BIT_IDX_W-1:0] lowest_clear(input word_t w);
    logic [BIT_IDX_W-1:0] n;
    n = BIT_IDX_W'(WORD_BITS - 1);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        n = BIT_IDX_W'(i);
      end
    end
    return n;
  endfunction

  bia_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORD_COUNT)
  ) u_bitmap (
    .clk  (clk),
    .we   (we),
    .waddr(idx_r),
    .wdata(wdata),
    .raddr(idx_r),
    .rdata(rdata)
  );

  assign accept      = in_tvalid && in_tready;
  assign can_emit    = !out_valid_r || out_tready;
  assign word_w      = vld_q_r ? rdata : '0;
  assign low_b       = lowest_clear(word_w);
  assign cand        = {idx_r, low_b};
  assign id_in_range = 32'(id_r) < 32'(CAPACITY);
  assign held_bit    = word_w[id_r[BIT_IDX_W-1:0]];
  assign rel_word    = (32'(in_tdata[7:BIT_IDX_W]) < 32'(WORD_COUNT))
                     ? AW'(in_tdata[7:BIT_IDX_W]) : '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (emit) begin
          state_nxt = ST_IDLE;
        end else if (func_r == FUNC_ALLOC && total_r < CAP_T && word_w == ALL_ONES
                     && idx_r != LAST_IDX) begin
          state_nxt = ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    func_nxt      = func_r;
    id_nxt        = id_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    we            = 1'b0;
    wdata         = word_w;
    emit          = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_id_nxt    = out_id_r;
    out_stat_nxt  = out_stat_r;
    out_total_nxt = out_total_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          func_nxt = func_t'(in_tuser[0]);
          id_nxt   = in_tdata;
          idx_nxt  = (func_t'(in_tuser[0]) == FUNC_ALLOC) ? '0 : rel_word;
        end
      end
      ST_READ: begin
      end
      ST_EVAL: begin
        if (can_emit) begin
          out_id_nxt    = '0;
          out_total_nxt = total_r;
          if (func_r == FUNC_ALLOC) begin
            if (total_r >= CAP_T) begin
              emit         = 1'b1;
              out_stat_nxt = STAT_FULL;
            end else if (word_w != ALL_ONES) begin
              emit = 1'b1;
              if (32'(cand) >= 32'(CAPACITY)) begin
                out_stat_nxt = STAT_FULL;
              end else begin
                we            = 1'b1;
                wdata         = word_w | (word_t'(1) << low_b);
                total_nxt     = total_r + TW'(1);
                out_total_nxt = total_r + TW'(1);
                out_id_nxt    = 8'(cand);
                out_stat_nxt  = STAT_OK;
              end
            end else if (idx_r == LAST_IDX) begin
              emit         = 1'b1;
              out_stat_nxt = STAT_FULL;
            end else begin
              idx_nxt = idx_r + AW'(1);
            end
          end else begin
            emit = 1'b1;
            if (!id_in_range || !held_bit) begin
              out_stat_nxt = STAT_NOT_HELD;
            end else begin
              we           = 1'b1;
              wdata        = word_w & ~(word_t'(1) << id_r[BIT_IDX_W-1:0]);
              out_stat_nxt = STAT_OK;
              if (total_r != '0) begin
                total_nxt     = total_r - TW'(1);
                out_total_nxt = total_r - TW'(1);
              end
            end
          end
          if (emit) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      vld_q_r     <= 1'b0;
      for (int i = 0; i < int'(WORD_COUNT); i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      vld_q_r     <= vld_r[idx_r];
      if (we) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    id_r        <= id_nxt;
    idx_r       <= idx_nxt;
    out_id_r    <= out_id_nxt;
    out_stat_r  <= out_stat_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {6'd0, (out_total_r != '0), 9'(out_total_r), out_id_r};

endmodule

@@ rtl/bia_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bia_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sim/bia_checker.sv @@
// Checker for the bitmap ID allocator: watches both stream channels, predicts each
// result from its own copy of the held-ID bitmap and compares every field.
// Depends on bia_pkg for the request and status codes.
module bia_checker
  import bia_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] id_in
  input  logic [0:0]  in_tuser,   // [0] func
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [7:0] id_out, [16:8] held_count, [17] any_held
  input  logic [1:0]  out_tuser,  // [1:0] status
  output int          fail_count,
  output int          pending
);

  localparam int unsigned MAP_WORDS = (CAPACITY + 63) / 64;

  typedef struct packed {
    logic [7:0] id;
    status_t    status;
    logic [8:0] held;
    logic       any;
  } grant_t;

  word_t      held_map [MAP_WORDS];
  logic [8:0] held_num;
  grant_t     due_results [$];
  int         errors;

  function automatic grant_t apply_request(func_t f, logic [7:0] id);
    grant_t      r;
    logic        found;
    int unsigned b;
    int unsigned cand;
    r = '{id: 8'd0, status: STAT_OK, held: 9'd0, any: 1'b0};
    if (f == FUNC_ALLOC) begin
      found = 1'b0;
      if (held_num < CAPACITY) begin
        for (int w = 0; w < MAP_WORDS; w++) begin
          if (!found && held_map[w] != {WORD_BITS{1'b1}}) begin
            b = 0;
            while (b < 63 && held_map[w][b]) b++;
            cand = w * WORD_BITS + b;
            if (cand < CAPACITY) begin
              held_map[w][b] = 1'b1;
              held_num = held_num + 9'd1;
              r.id = cand[7:0];
              found = 1'b1;
            end else begin
              w = MAP_WORDS;
            end
          end
        end
      end
      if (!found) r.status = STAT_FULL;
    end else begin
      if (id >= CAPACITY || (id >> 6) >= MAP_WORDS || !held_map[id >> 6][id[5:0]]) begin
        r.status = STAT_NOT_HELD;
      end else begin
        held_map[id >> 6][id[5:0]] = 1'b0;
        if (held_num != 0) held_num = held_num - 9'd1;
      end
    end
    r.held = held_num;
    r.any  = (held_num != 0);
    return r;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    grant_t got;
    if (!rst_n) begin
      for (int w = 0; w < MAP_WORDS; w++) held_map[w] = '0;
      held_num = '0;
      due_results.delete();
      errors = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{id: out_tdata[7:0], status: status_t'(out_tuser), held: out_tdata[16:8],
                any: out_tdata[17]};
        if (due_results.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected word id=%0d status=%0d held=%0d any=%0b",
                     $realtime, got.id, got.status, got.held, got.any);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display("%0t: mismatch exp id=%0d status=%0d held=%0d any=%0b, got id=%0d status=%0d held=%0d any=%0b",
                       $realtime, want.id, want.status, want.held, want.any,
                       got.id, got.status, got.held, got.any);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready)
        due_results.push_back(apply_request(func_t'(in_tuser[0]), in_tdata));
    end
    fail_count <= errors;
    pending    <= due_results.size();
  end

endmodule

@@ sim/tb.sv @@
// Testbench top for the bitmap ID allocator: clock, reset, request stimulus and verdict.
// Depends on bia_pkg, bitmap_id_allocator and bia_checker.
module tb;
  import bia_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] id_in
  logic [0:0]  in_tuser;   // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;  // [7:0] id_out, [16:8] held_count, [17] any_held
  logic [1:0]  out_tuser;  // [1:0] status
  int          fail_count;
  int          pending;
  int          send_idle;
  int          recv_idle;

  bitmap_id_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  bia_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .fail_count(fail_count), .pending(pending)
  );

  always #10 clk = ~clk;

  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle);

  // call at a falling edge; returns at a falling edge after the word is taken
  task automatic send_request(func_t f, logic [7:0] id);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= id;
    in_tuser  <= f;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_release();
    logic [7:0] id;
    case ($urandom_range(3))
      0:       id = 8'($urandom_range(255));
      1:       id = 8'($urandom_range(255, 192));
      default: id = 8'($urandom_range(63));
    endcase
    send_request(FUNC_RELEASE, id);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = FUNC_ALLOC;
    send_idle  = 9;
    recv_idle  = 72;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(FUNC_RELEASE, 8'd0);
    send_request(FUNC_RELEASE, 8'd255);
    repeat (4) send_request(FUNC_ALLOC, 8'd0);
    send_request(FUNC_ALLOC, 8'd255);
    send_request(FUNC_RELEASE, 8'd1);
    send_request(FUNC_RELEASE, 8'd1);
    send_request(FUNC_ALLOC, 8'hAA);
    send_request(FUNC_RELEASE, 8'd4);
    send_request(FUNC_RELEASE, 8'd0);
    send_request(FUNC_RELEASE, 8'd64);
    send_request(FUNC_RELEASE, 8'd63);
    send_request(FUNC_ALLOC, 8'd0);
    send_request(FUNC_RELEASE, 8'd2);
    send_request(FUNC_RELEASE, 8'd3);
    send_request(FUNC_RELEASE, 8'd0);
    send_request(FUNC_RELEASE, 8'd1);
    send_request(FUNC_RELEASE, 8'd128);

    for (int m = 0; m < 3; m++) begin
      send_idle = (m == 0) ? 9 : (m == 1) ? 72 : 0;
      recv_idle = (m == 0) ? 72 : (m == 1) ? 9 : 0;
      // fill past capacity, then drain
      for (int i = 0; i < 465; i++) begin
        if (i < 310 ? ($urandom_range(99) < 92) : ($urandom_range(99) < 15))
          send_request(FUNC_ALLOC, 8'($urandom_range(255)));
        else
          random_release();
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

@@ bitmap_id_allocator.f @@
rtl/bia_pkg.sv
rtl/bia_ram.sv
rtl/bitmap_id_allocator.sv
sim/bia_checker.sv
sim/tb.sv
